FILE: hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 7;

  localparam logic [KIND_W-1:0] KIND_ADD_FIRST  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_LAST   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT_AT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAKE_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TAKE_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED     = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BOUNDS = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// Pushes, pops, inserts and removals shift the whole cell chain at the edge that accepts them.
// The result word is registered and appears on the cycle after the request is accepted.
// A dump rotates the chain and gives one word per unstalled cycle per element, front to back.
// A new request is taken when the output register is free or being emptied, but not in a dump.
// Synchronous active-low reset empties the list; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [ple_pkg::KIND_W-1:0]     in_kind,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]    in_value,
  input  wire logic        [ple_pkg::POS_W-1:0]      in_position,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic             [ple_pkg::STATUS_W-1:0]   out_status,
  output logic signed      [ple_pkg::VALUE_W-1:0]    out_item,
  output logic             [ple_pkg::SIZE_W-1:0]     out_size_now,
  output logic                                       out_last
);

  ple_pkg::state_t state_r;
  ple_pkg::state_t state_nxt;

  logic [ple_pkg::CNT_W-1:0] occ_r;
  logic [ple_pkg::CNT_W-1:0] occ_nxt;
  logic [ple_pkg::CNT_W-1:0] dump_left_r;
  logic [ple_pkg::CNT_W-1:0] dump_left_nxt;

  logic                                   out_valid_r;
  logic [ple_pkg::STATUS_W-1:0]           out_status_r;
  logic signed [ple_pkg::VALUE_W-1:0]     out_item_r;
  logic [ple_pkg::SIZE_W-1:0]             out_size_r;
  logic                                   out_last_r;

  logic                                   load_out;
  logic [ple_pkg::STATUS_W-1:0]           res_status;
  logic signed [ple_pkg::VALUE_W-1:0]     res_item;
  logic                                   res_last;

  logic                                   out_free;
  logic                                   in_fire;
  logic [ple_pkg::SIZE_W-1:0]             occ_w;
  logic [ple_pkg::IDX_W-1:0]              pos_idx;
  logic [ple_pkg::IDX_W-1:0]              back_idx;
  logic [ple_pkg::IDX_W-1:0]              tail_idx;
  logic                                   ins_ok;
  logic                                   rem_ok;
  logic                                   is_full;
  logic                                   is_empty;

  ple_pkg::cell_cmd_t                     cmd;
  logic signed [ple_pkg::VALUE_W-1:0]     cell_q [ple_pkg::CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < ple_pkg::CAPACITY; gi++) begin : g_cell
      ple_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .cell_idx (ple_pkg::IDX_W'(gi)),
        .left_i   (cell_q[(gi > 0) ? gi - 1 : gi]),
        .right_i  (cell_q[(gi < ple_pkg::CAPACITY - 1) ? gi + 1 : gi]),
        .load_i   (in_value),
        .head_i   (cell_q[0]),
        .data_o   (cell_q[gi])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign occ_w    = ple_pkg::SIZE_W'(occ_r);
  assign pos_idx  = ple_pkg::IDX_W'(in_position - ple_pkg::POS_W'(1));
  assign back_idx = ple_pkg::IDX_W'(occ_r);
  assign tail_idx = ple_pkg::IDX_W'(occ_r - ple_pkg::CNT_W'(1));
  assign is_full  = (occ_r >= ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign is_empty = (occ_r == '0);
  assign ins_ok   = (in_position != '0) && (in_position <= occ_w + ple_pkg::SIZE_W'(1));
  assign rem_ok   = (in_position != '0) && (in_position <= occ_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_valid && out_free && (in_kind == ple_pkg::KIND_DUMP)
            && (occ_r > ple_pkg::CNT_W'(1))) begin
          state_nxt = ple_pkg::S_DUMP;
        end
      end
      ple_pkg::S_DUMP: begin
        if (out_free && (dump_left_r == ple_pkg::CNT_W'(1))) begin
          state_nxt = ple_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.op        = ple_pkg::CELL_HOLD;
    cmd.idx       = '0;
    load_out      = 1'b0;
    res_status    = ple_pkg::STATUS_OK;
    res_item      = '0;
    res_last      = 1'b1;
    occ_nxt       = occ_r;
    dump_left_nxt = dump_left_r;
    unique case (state_r)
      ple_pkg::S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          load_out = 1'b1;
          unique case (in_kind)
            ple_pkg::KIND_ADD_FIRST, ple_pkg::KIND_ADD_LAST: begin
              if (is_full) begin
                res_status = ple_pkg::STATUS_FULL;
              end else begin
                cmd.op  = ple_pkg::CELL_INSERT;
                cmd.idx = (in_kind == ple_pkg::KIND_ADD_FIRST) ? '0 : back_idx;
                occ_nxt = occ_r + ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::KIND_INSERT_AT: begin
              if (!ins_ok) begin
                res_status = ple_pkg::STATUS_BOUNDS;
              end else if (is_full) begin
                res_status = ple_pkg::STATUS_FULL;
              end else begin
                cmd.op  = ple_pkg::CELL_INSERT;
                cmd.idx = pos_idx;
                occ_nxt = occ_r + ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::KIND_TAKE_FIRST, ple_pkg::KIND_TAKE_LAST: begin
              if (is_empty) begin
                res_status = ple_pkg::STATUS_EMPTY;
              end else begin
                cmd.op   = ple_pkg::CELL_REMOVE;
                cmd.idx  = (in_kind == ple_pkg::KIND_TAKE_FIRST) ? '0 : tail_idx;
                res_item = cell_q[cmd.idx];
                occ_nxt  = occ_r - ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::KIND_REMOVE_AT: begin
              if (is_empty) begin
                res_status = ple_pkg::STATUS_EMPTY;
              end else if (!rem_ok) begin
                res_status = ple_pkg::STATUS_BOUNDS;
              end else begin
                cmd.op   = ple_pkg::CELL_REMOVE;
                cmd.idx  = pos_idx;
                res_item = cell_q[pos_idx];
                occ_nxt  = occ_r - ple_pkg::CNT_W'(1);
              end
            end
            ple_pkg::KIND_DUMP: begin
              if (is_empty) begin
                res_status = ple_pkg::STATUS_EMPTY;
              end else begin
                cmd.op        = ple_pkg::CELL_ROTATE;
                cmd.idx       = tail_idx;
                res_item      = cell_q[0];
                res_last      = (occ_r == ple_pkg::CNT_W'(1));
                dump_left_nxt = occ_r - ple_pkg::CNT_W'(1);
              end
            end
            default: begin
              res_status = ple_pkg::STATUS_OK;
            end
          endcase
        end
      end
      ple_pkg::S_DUMP: begin
        if (out_free) begin
          load_out      = 1'b1;
          cmd.op        = ple_pkg::CELL_ROTATE;
          cmd.idx       = tail_idx;
          res_item      = cell_q[0];
          res_last      = (dump_left_r == ple_pkg::CNT_W'(1));
          dump_left_nxt = dump_left_r - ple_pkg::CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::S_IDLE;
      occ_r       <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dump_left_r <= dump_left_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_item_r   <= res_item;
      out_size_r   <= ple_pkg::SIZE_W'(occ_nxt);
      out_last_r   <= res_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_item     = out_item_r;
  assign out_size_now = out_size_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("Element count exceeds capacity.");

  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::S_DUMP) == (dump_left_r != '0))
    else $error("Dump counter disagrees with the state.");

  a_partial_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (state_r == ple_pkg::S_DUMP))
    else $error("Non-final word outside a dump.");

  a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !in_fire) |=> $stable(occ_r))
    else $error("Element count changed without a request.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ple_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_cell (
  input  wire logic                                 clk,
  input  wire ple_pkg::cell_cmd_t                   cmd,
  input  wire logic        [ple_pkg::IDX_W-1:0]     cell_idx,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]   left_i,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]   right_i,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]   load_i,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]   head_i,
  output logic signed      [ple_pkg::VALUE_W-1:0]   data_o
);

  logic signed [ple_pkg::VALUE_W-1:0] data_r;
  logic signed [ple_pkg::VALUE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      ple_pkg::CELL_HOLD: begin
        data_nxt = data_r;
      end
      ple_pkg::CELL_INSERT: begin
        if (cell_idx > cmd.idx) begin
          data_nxt = left_i;
        end else if (cell_idx == cmd.idx) begin
          data_nxt = load_i;
        end
      end
      ple_pkg::CELL_REMOVE: begin
        if (cell_idx >= cmd.idx) begin
          data_nxt = right_i;
        end
      end
      ple_pkg::CELL_ROTATE: begin
        if (cell_idx < cmd.idx) begin
          data_nxt = right_i;
        end else if (cell_idx == cmd.idx) begin
          data_nxt = head_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

FILE: bench/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;

  typedef struct packed {
    logic [ple_pkg::STATUS_W-1:0]       status;
    logic signed [ple_pkg::VALUE_W-1:0] item;
    logic [ple_pkg::SIZE_W-1:0]         size_now;
    logic                               last;
  } list_word_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [ple_pkg::KIND_W-1:0]         in_kind;
  logic signed [ple_pkg::VALUE_W-1:0] in_value;
  logic [ple_pkg::POS_W-1:0]          in_position;
  logic                               out_valid;
  logic                               out_stall;
  logic [ple_pkg::STATUS_W-1:0]       out_status;
  logic signed [ple_pkg::VALUE_W-1:0] out_item;
  logic [ple_pkg::SIZE_W-1:0]         out_size_now;
  logic                               out_last;

  list_word_t                         expected_words[$];
  logic signed [ple_pkg::VALUE_W-1:0] held_values[$];
  int                                 errors;
  bit                                 steady;

  positional_list_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_item    (out_item),
    .out_size_now(out_size_now),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned wait_cycles();
    if (steady) begin
      return 0;
    end
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string text);
    if (errors < 40) begin
      $display("mismatch: %s", text);
    end
    errors++;
  endtask

  function automatic void expect_word(input list_word_t word);
    expected_words.insert(expected_words.size(), word);
  endfunction

  // Applies one request to the list copy and queues the words it should produce.
  function automatic void predict_request(input logic [ple_pkg::KIND_W-1:0] kind,
                                          input logic signed [ple_pkg::VALUE_W-1:0] value,
                                          input logic [ple_pkg::POS_W-1:0] position);
    logic [ple_pkg::STATUS_W-1:0]       status;
    logic signed [ple_pkg::VALUE_W-1:0] taken;
    int                                 count;
    int                                 pos;
    status = ple_pkg::STATUS_OK;
    taken  = '0;
    count  = held_values.size();
    pos    = int'(position);
    case (kind)
      ple_pkg::KIND_ADD_FIRST, ple_pkg::KIND_ADD_LAST: begin
        if (count >= ple_pkg::CAPACITY) begin
          status = ple_pkg::STATUS_FULL;
        end else if (kind == ple_pkg::KIND_ADD_FIRST) begin
          held_values.insert(0, value);
        end else begin
          held_values.insert(count, value);
        end
      end
      ple_pkg::KIND_INSERT_AT: begin
        if (pos < 1 || pos > count + 1) begin
          status = ple_pkg::STATUS_BOUNDS;
        end else if (count >= ple_pkg::CAPACITY) begin
          status = ple_pkg::STATUS_FULL;
        end else begin
          held_values.insert(pos - 1, value);
        end
      end
      ple_pkg::KIND_TAKE_FIRST: begin
        if (count == 0) begin
          status = ple_pkg::STATUS_EMPTY;
        end else begin
          taken = held_values[0];
          held_values.delete(0);
        end
      end
      ple_pkg::KIND_TAKE_LAST: begin
        if (count == 0) begin
          status = ple_pkg::STATUS_EMPTY;
        end else begin
          taken = held_values[count - 1];
          held_values.delete(count - 1);
        end
      end
      ple_pkg::KIND_REMOVE_AT: begin
        if (count == 0) begin
          status = ple_pkg::STATUS_EMPTY;
        end else if (pos < 1 || pos > count) begin
          status = ple_pkg::STATUS_BOUNDS;
        end else begin
          taken = held_values[pos - 1];
          held_values.delete(pos - 1);
        end
      end
      ple_pkg::KIND_DUMP: begin
        if (count == 0) begin
          expect_word(list_word_t'{ple_pkg::STATUS_EMPTY, '0, '0, 1'b1});
        end else begin
          for (int i = 0; i < count; i++) begin
            expect_word(list_word_t'{ple_pkg::STATUS_OK, held_values[i],
                                     ple_pkg::SIZE_W'(count), i == count - 1});
          end
        end
        return;
      end
      default: ;
    endcase
    expect_word(list_word_t'{status, taken, ple_pkg::SIZE_W'(held_values.size()), 1'b1});
  endfunction

  task automatic send_request(input logic [ple_pkg::KIND_W-1:0] kind,
                              input logic signed [ple_pkg::VALUE_W-1:0] value,
                              input logic [ple_pkg::POS_W-1:0] position);
    int unsigned gap;
    gap = wait_cycles();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_request(kind, value, position);
  endtask

  // Well-formed positions mostly, with an occasional one drawn from 0 to 64.
  task automatic send_random_op(input int grow_pct);
    logic [ple_pkg::KIND_W-1:0] kind;
    logic [ple_pkg::POS_W-1:0]  position;
    int                         count;
    count = held_values.size();
    if ($urandom_range(0, 99) < 6) begin
      kind = ple_pkg::KIND_DUMP;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0: kind = ple_pkg::KIND_ADD_FIRST;
        1: kind = ple_pkg::KIND_ADD_LAST;
        default: kind = ple_pkg::KIND_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: kind = ple_pkg::KIND_TAKE_FIRST;
        1: kind = ple_pkg::KIND_TAKE_LAST;
        default: kind = ple_pkg::KIND_REMOVE_AT;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      position = ple_pkg::POS_W'($urandom_range(0, 64));
    end else if (kind == ple_pkg::KIND_INSERT_AT) begin
      position = ple_pkg::POS_W'($urandom_range(1, count + 1));
    end else begin
      position = ple_pkg::POS_W'($urandom_range(1, (count > 0) ? count : 1));
    end
    send_request(kind, pick_value(), position);
  endtask

  task automatic test_empty_list();
    send_request(ple_pkg::KIND_TAKE_FIRST, 32'sd5, 7'd1);
    send_request(ple_pkg::KIND_TAKE_LAST, 32'sd5, 7'd1);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd5, 7'd1);
    send_request(ple_pkg::KIND_DUMP, 32'sd5, 7'd0);
    send_request(ple_pkg::KIND_UNUSED, 32'sd5, 7'd3);
    send_request(ple_pkg::KIND_INSERT_AT, 32'sd9, 7'd0);
    send_request(ple_pkg::KIND_INSERT_AT, 32'sd9, 7'd2);
    send_request(ple_pkg::KIND_INSERT_AT, 32'sh7fff_ffff, 7'd1);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd0, 7'd2);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd0, 7'd0);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd0, 7'd1);
  endtask

  task automatic test_extreme_values();
    send_request(ple_pkg::KIND_ADD_LAST, 32'sh8000_0000, 7'd0);
    send_request(ple_pkg::KIND_ADD_FIRST, 32'sh7fff_ffff, 7'd127);
    send_request(ple_pkg::KIND_ADD_LAST, -32'sd1, 7'd64);
    send_request(ple_pkg::KIND_INSERT_AT, 32'sh5555_5555, 7'd4);
    send_request(ple_pkg::KIND_INSERT_AT, 32'shaaaa_aaaa, 7'd2);
    send_request(ple_pkg::KIND_INSERT_AT, 32'sd1, 7'd64);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd1, 7'd64);
    send_request(ple_pkg::KIND_UNUSED, 32'sd1, 7'd1);
    send_request(ple_pkg::KIND_DUMP, 32'sd0, 7'd0);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd0, 7'd2);
    send_request(ple_pkg::KIND_TAKE_LAST, 32'sd0, 7'd0);
    send_request(ple_pkg::KIND_TAKE_FIRST, 32'sd0, 7'd0);
    send_request(ple_pkg::KIND_REMOVE_AT, 32'sd0, 7'd2);
  endtask

  task automatic test_full_list();
    while (held_values.size() < ple_pkg::CAPACITY) begin
      send_random_op(100);
    end
    send_request(ple_pkg::KIND_ADD_FIRST, pick_value(), 7'd1);
    send_request(ple_pkg::KIND_ADD_LAST, pick_value(), 7'd1);
    send_request(ple_pkg::KIND_INSERT_AT, pick_value(),
                 ple_pkg::POS_W'(ple_pkg::CAPACITY + 1));
    send_request(ple_pkg::KIND_INSERT_AT, pick_value(),
                 ple_pkg::POS_W'($urandom_range(1, ple_pkg::CAPACITY)));
    send_request(ple_pkg::KIND_INSERT_AT, pick_value(),
                 ple_pkg::POS_W'(ple_pkg::CAPACITY + 2));
    send_request(ple_pkg::KIND_DUMP, pick_value(), 7'd0);
    send_request(ple_pkg::KIND_REMOVE_AT, pick_value(), ple_pkg::POS_W'(ple_pkg::CAPACITY));
    while (held_values.size() > 0) begin
      send_random_op(0);
    end
    send_request(ple_pkg::KIND_TAKE_LAST, pick_value(), 7'd0);
  endtask

  task automatic test_random_mix();
    int sent;
    int chunk;
    int grow_pct;
    sent = 0;
    while (sent < 390) begin
      chunk = $urandom_range(16, 48);
      case ($urandom_range(0, 2))
        0: grow_pct = 75;
        1: grow_pct = 25;
        default: grow_pct = 50;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat (chunk) begin
        send_random_op(grow_pct);
      end
      sent += chunk;
    end
    steady = 1'b0;
  endtask

  always begin : result_sink
    int unsigned hold;
    list_word_t  got;
    list_word_t  want;
    wait (rst_n === 1'b1);
    hold = wait_cycles();
    repeat (hold) begin
      @(negedge clk);
      out_stall <= 1'b1;
    end
    @(negedge clk);
    out_stall <= 1'b0;
    do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    got = '{out_status, out_item, out_size_now, out_last};
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with none expected: status %0d item %0d size %0d",
                                got.status, got.item, got.size_now));
    end else begin
      want = expected_words[0];
      expected_words.delete(0);
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.item !== want.item) begin
        report_mismatch($sformatf("item %0d, expected %0d", got.item, want.item));
      end
      if (got.size_now !== want.size_now) begin
        report_mismatch($sformatf("size_now %0d, expected %0d", got.size_now,
                                  want.size_now));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  initial begin
    errors      = 0;
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind     = '0;
    in_value    = '0;
    in_position = '0;
    out_stall   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_list();
    test_extreme_values();
    test_full_list();
    test_random_mix();
    @(negedge clk);
    in_valid <= 1'b0;
    steady = 1'b1;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_positional_list_engine: clean");
    end else begin
      $display("tb_positional_list_engine: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_positional_list_engine: errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine.sv
bench/tb_positional_list_engine.sv
